@@ design/ptw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types, codes and a helper function for the four-level page table
// walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

  localparam int VA_W      = 48;
  localparam int ENTRY_W   = 64;
  localparam int PADDR_W   = 63;
  localparam int FRAME_W   = 51;
  localparam int IDX_W     = 9;
  localparam int LEVEL_W   = 3;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 64;

  // Action codes carried on the input channel.
  localparam logic ACT_TRANSLATE = 1'b0;
  localparam logic ACT_RESPONSE  = 1'b1;

  // Kind codes carried on the output channel.
  localparam logic KIND_READ_REQ = 1'b0;
  localparam logic KIND_RESULT   = 1'b1;

  // Translation status codes.
  localparam logic [1:0] ST_MAPPED_4K   = 2'd0;
  localparam logic [1:0] ST_MAPPED_2M   = 2'd1;
  localparam logic [1:0] ST_NOT_PRESENT = 2'd2;
  localparam logic [1:0] ST_HUGE_1G     = 2'd3;

  // Walk level codes. Any code with the top bit set is idle.
  localparam logic [LEVEL_W-1:0] LVL_PML4 = 3'd0;
  localparam logic [LEVEL_W-1:0] LVL_PDP  = 3'd1;
  localparam logic [LEVEL_W-1:0] LVL_PD   = 3'd2;
  localparam logic [LEVEL_W-1:0] LVL_PT   = 3'd3;
  localparam logic [LEVEL_W-1:0] LVL_IDLE = 3'd4;

  // Table entry bits.
  localparam int ENTRY_PRESENT_BIT = 0;
  localparam int ENTRY_HUGE_BIT    = 7;
  localparam int ENTRY_FRAME_LSB   = 12;

  // Configuration register byte addresses.
  localparam logic [APB_ADDR_W-1:0] REG_ROOT_FRAME = 4'h0;

  typedef struct packed {
    logic               kind;
    logic [PADDR_W-1:0] read_address;
    logic [1:0]         status;
    logic [FRAME_W-1:0] phys_frame;
    logic [1:0]         fault_level;
  } walk_result_t;

  // Table index of the virtual address for a given level.
  function automatic logic [IDX_W-1:0] entry_index(input logic [VA_W-1:0] va,
                                                   input logic [1:0]      lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

@@ design/ptw_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_if
// Valid/ready channel interfaces for walker input items and walker results.
// ----------------------------------------------------------------------------
interface ptw_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [ptw_pkg::VA_W-1:0]    virtual_address;
  logic [ptw_pkg::ENTRY_W-1:0] read_data;

  modport source (output valid, action, virtual_address, read_data, input ready);
  modport sink   (input valid, action, virtual_address, read_data, output ready);
endinterface

interface ptw_out_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [ptw_pkg::PADDR_W-1:0] read_address;
  logic [1:0]                  status;
  logic [ptw_pkg::FRAME_W-1:0] phys_frame;
  logic [1:0]                  fault_level;

  modport source (output valid, kind, read_address, status, phys_frame, fault_level,
                  input ready);
  modport sink   (input valid, kind, read_address, status, phys_frame, fault_level,
                  output ready);
endinterface

@@ design/four_level_page_table_walker_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_table_walker_top
// Walks x86-64 four-level page tables for 48-bit virtual addresses, issuing
// one entry read request per level and returning a translation result.
// ----------------------------------------------------------------------------
//
// Channel    Direction  Transfer contents
// walk_in    sink       action, virtual_address, read_data
// walk_out   source     kind, read_address, status, phys_frame, fault_level
// APB        slave      root_frame register at byte address 0
//
// Each input item is decoded in the cycle it is transferred and its result
// is written into the output register, or into the skid register while
// that is held, so one item can be taken every clock. The two-entry output
// stage keeps walk_in.ready a registered signal; input stalls only when both
// entries hold results. Reset (rst, synchronous) returns the walker to idle,
// clears root_frame and empties the output stage. Dropped items (translate
// while busy, response while idle) produce no transfer on walk_out.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_top (
  input  logic                              clk,
  input  logic                              rst,
  ptw_in_if.sink                            walk_in,
  ptw_out_if.source                         walk_out,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ptw_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [ptw_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ptw_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import ptw_pkg::*;

  logic [FRAME_W-1:0] root_frame;
  logic [LEVEL_W-1:0] walk_level;
  logic [LEVEL_W-1:0] walk_level_next;
  logic [VA_W-1:0]    saved_address;
  logic [VA_W-1:0]    saved_address_next;

  logic               in_fire;
  logic               walk_idle;
  logic               res_valid;
  walk_result_t       res;

  logic               out_valid;
  walk_result_t       out_data;
  logic               skid_valid;
  walk_result_t       skid_data;
  logic               out_take;

  // --------------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; pready is tied
  // high so there are no wait states.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_frame <= '0;
    end else if (psel && penable && pwrite && pready && (paddr == REG_ROOT_FRAME)) begin
      root_frame <= pwdata[FRAME_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_ROOT_FRAME) begin
      prdata = {{(APB_DATA_W-FRAME_W){1'b0}}, root_frame};
    end
  end

  // --------------------------------------------------------------------------
  // Walk decode. Codes above the PT level all count as idle.
  // --------------------------------------------------------------------------
  assign walk_in.ready = !skid_valid;
  assign in_fire       = walk_in.valid && walk_in.ready;
  assign walk_idle     = walk_level[LEVEL_W-1];

  always_comb begin
    logic [ENTRY_W-1:0] entry;
    logic [1:0]         lvl;
    logic [1:0]         lvl_plus;
    entry              = walk_in.read_data;
    lvl                = walk_level[1:0];
    lvl_plus           = lvl + 2'd1;
    walk_level_next    = walk_level;
    saved_address_next = saved_address;
    res_valid          = 1'b0;
    res                = '0;

    if (in_fire) begin
      if (walk_in.action == ACT_TRANSLATE) begin
        if (walk_idle) begin
          // Table bases are 4 KB aligned, so base plus index*8 is a concat.
          saved_address_next = walk_in.virtual_address;
          walk_level_next    = LVL_PML4;
          res_valid          = 1'b1;
          res.kind           = KIND_READ_REQ;
          res.read_address   = {root_frame,
                                entry_index(walk_in.virtual_address, 2'd0), 3'b000};
        end
      end else if (!walk_idle) begin
        res_valid       = 1'b1;
        walk_level_next = LVL_IDLE;
        if (!entry[ENTRY_PRESENT_BIT]) begin
          res.kind        = KIND_RESULT;
          res.status      = ST_NOT_PRESENT;
          res.fault_level = lvl;
        end else if (walk_level == LVL_PDP && entry[ENTRY_HUGE_BIT]) begin
          res.kind   = KIND_RESULT;
          res.status = ST_HUGE_1G;
        end else if (walk_level == LVL_PD && entry[ENTRY_HUGE_BIT]) begin
          res.kind       = KIND_RESULT;
          res.status     = ST_MAPPED_2M;
          res.phys_frame = entry[ENTRY_W-2:ENTRY_FRAME_LSB];
        end else if (walk_level == LVL_PT) begin
          res.kind       = KIND_RESULT;
          res.status     = ST_MAPPED_4K;
          res.phys_frame = entry[ENTRY_W-2:ENTRY_FRAME_LSB];
        end else begin
          // Descend one level; the next table base comes from entry bits 62:12.
          walk_level_next  = {1'b0, lvl_plus};
          res.kind         = KIND_READ_REQ;
          res.read_address = {entry[ENTRY_W-2:ENTRY_FRAME_LSB],
                              entry_index(saved_address, lvl_plus), 3'b000};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_level    <= LVL_IDLE;
      saved_address <= '0;
    end else begin
      walk_level    <= walk_level_next;
      saved_address <= saved_address_next;
    end
  end

  // --------------------------------------------------------------------------
  // Output register with skid entry. A new result can only arrive while the
  // skid entry is empty, since input ready is the inverse of skid_valid.
  // --------------------------------------------------------------------------
  assign out_take = !out_valid || walk_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= res_valid;
      end else begin
        out_valid  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      if (skid_valid) begin
        out_data  <= skid_data;
        skid_data <= res;
      end else begin
        out_data  <= res;
      end
    end else if (res_valid) begin
      skid_data <= res;
    end
  end

  assign walk_out.valid        = out_valid;
  assign walk_out.kind         = out_data.kind;
  assign walk_out.read_address = out_data.read_address;
  assign walk_out.status       = out_data.status;
  assign walk_out.phys_frame   = out_data.phys_frame;
  assign walk_out.fault_level  = out_data.fault_level;

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a result while the output register is empty");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    walk_level <= LVL_IDLE)
    else $error("walk level left the legal range");

  a_start_walk: assert property (@(posedge clk) disable iff (rst)
    (in_fire && walk_in.action == ACT_TRANSLATE && walk_idle) |=> walk_level == LVL_PML4)
    else $error("accepted translate did not start a walk at the PML4 level");

  a_result_ends_walk: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == KIND_RESULT) |=> walk_level == LVL_IDLE)
    else $error("translation result did not return the walker to idle");

  a_no_result_when_dropped: assert property (@(posedge clk) disable iff (rst)
    (in_fire && walk_in.action == ACT_RESPONSE && walk_idle) |-> !res_valid)
    else $error("response while idle produced a result");
`endif

endmodule

@@ verif/ptw_walk_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_walk_checker
// Watches the walker's input channel, output channel and register port, keeps
// its own model of the walk and compares every output transfer with it.
// ----------------------------------------------------------------------------
module ptw_walk_checker (
  input  logic                           clk,
  input  logic                           rst,
  ptw_in_if                              walk_in,
  ptw_out_if                             walk_out,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [ptw_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ptw_pkg::APB_DATA_W-1:0] pwdata,
  output int                             pending,
  output int                             fail_count
);
  import ptw_pkg::*;

  logic [FRAME_W-1:0] root_frame_q;
  logic [LEVEL_W-1:0] walk_lvl;
  logic [VA_W-1:0]    walk_va;
  walk_result_t       expected_q[$];
  walk_result_t       want;
  int                 errors = 0;

  task automatic flag_error(input string msg);
    $display("%0t ns: ERROR %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] exp_val);
    if (got !== exp_val)
      flag_error($sformatf("%s is %h, expected %h", name, got, exp_val));
  endtask

  // Byte offset of the entry for one level inside its table.
  function automatic logic [63:0] entry_offset(input logic [VA_W-1:0] va,
                                               input logic [LEVEL_W-1:0] lvl);
    logic [VA_W-1:0] shifted;
    shifted = va >> (39 - 9 * int'(lvl));
    return {52'd0, shifted[8:0], 3'b000};
  endfunction

  function automatic walk_result_t read_request(input logic [63:0] addr);
    walk_result_t r;
    r = '0;
    r.kind = KIND_READ_REQ;
    r.read_address = addr[PADDR_W-1:0];
    return r;
  endfunction

  function automatic walk_result_t walk_done(input logic [1:0] status,
                                             input logic [FRAME_W-1:0] frame,
                                             input logic [1:0] flevel);
    walk_result_t r;
    r = '0;
    r.kind = KIND_RESULT;
    r.status = status;
    r.phys_frame = frame;
    r.fault_level = flevel;
    return r;
  endfunction

  // Advances the walk by one accepted input item and queues what it causes.
  function automatic void walk_step(input logic action, input logic [VA_W-1:0] va,
                                    input logic [ENTRY_W-1:0] entry);
    logic [63:0]        base;
    logic [LEVEL_W-1:0] lvl;
    base = entry & 64'h7fff_ffff_ffff_f000;
    lvl = walk_lvl;
    if (action == ACT_TRANSLATE) begin
      // A translate during a walk is dropped.
      if (walk_lvl > LVL_PT) begin
        walk_va = va;
        walk_lvl = LVL_PML4;
        expected_q.push_back(read_request(({13'd0, root_frame_q} << 12) +
                                          entry_offset(va, LVL_PML4)));
      end
    end else if (walk_lvl <= LVL_PT) begin
      if (!entry[ENTRY_PRESENT_BIT]) begin
        walk_lvl = LVL_IDLE;
        expected_q.push_back(walk_done(ST_NOT_PRESENT, '0, lvl[1:0]));
      end else if (lvl == LVL_PDP && entry[ENTRY_HUGE_BIT]) begin
        walk_lvl = LVL_IDLE;
        expected_q.push_back(walk_done(ST_HUGE_1G, '0, 2'd0));
      end else if (lvl == LVL_PD && entry[ENTRY_HUGE_BIT]) begin
        walk_lvl = LVL_IDLE;
        expected_q.push_back(walk_done(ST_MAPPED_2M, base[62:12], 2'd0));
      end else if (lvl == LVL_PT) begin
        walk_lvl = LVL_IDLE;
        expected_q.push_back(walk_done(ST_MAPPED_4K, base[62:12], 2'd0));
      end else begin
        walk_lvl = lvl + 3'd1;
        expected_q.push_back(read_request(base + entry_offset(walk_va, walk_lvl)));
      end
    end
  endfunction

  // Outputs are compared before the input of the same edge is modeled; an
  // item taken at this edge cannot leave the block before the next one.
  always @(posedge clk) begin
    if (rst) begin
      root_frame_q = '0;
      walk_lvl = LVL_IDLE;
      walk_va = '0;
      expected_q.delete();
    end else begin
      if (walk_out.valid && walk_out.ready) begin
        if (expected_q.size() == 0) begin
          flag_error($sformatf("transfer with nothing expected: kind %0d addr %h status %0d",
                               walk_out.kind, walk_out.read_address, walk_out.status));
        end else begin
          want = expected_q.pop_front();
          check_field("kind", 64'(walk_out.kind), 64'(want.kind));
          check_field("read_address", 64'(walk_out.read_address),
                      64'(want.read_address));
          check_field("status", 64'(walk_out.status), 64'(want.status));
          check_field("phys_frame", 64'(walk_out.phys_frame), 64'(want.phys_frame));
          check_field("fault_level", 64'(walk_out.fault_level),
                      64'(want.fault_level));
        end
      end
      if (psel && penable && pwrite && pready && paddr == REG_ROOT_FRAME)
        root_frame_q = pwdata[FRAME_W-1:0];
      if (walk_in.valid && walk_in.ready)
        walk_step(walk_in.action, walk_in.virtual_address, walk_in.read_data);
    end
    pending <= expected_q.size();
    fail_count <= errors;
  end

endmodule

@@ verif/four_level_page_table_walker_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_table_walker_top_tb
// Drives page walks into the walker and lets the checker judge every result.
// ----------------------------------------------------------------------------
//
// The bench plays the part of the translation client and of memory at the
// same time: it sends a translate, then answers each read request with a
// table entry whose present and page-size bits are chosen so that the walk
// goes deeper, ends on a large page, or faults. Because the block takes
// items strictly in order, the bench does not wait for the read request
// before it sends the matching response; it only keeps track of the level
// that the walk it is driving has reached.
//
// A short directed part covers the extremes first: all-zero and all-one
// addresses and entries, a fault at every level, 1 GB and 2 MB pages, the
// page-size bit at the PML4 and PT levels (which the walker ignores), and
// both kinds of dropped item. The random part then runs in four phases with
// different idle and stall patterns and different root frames. Between
// phases the bench waits until every expected result has arrived before it
// writes the root frame register again.
//
// All checking lives in ptw_walk_checker; this module only makes stimulus
// and gives the verdict.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_top_tb;
  import ptw_pkg::*;

  localparam int ITEMS_PER_PHASE = 175;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int pending;
  int fail_count;

  // Percentages of cycles in which the sender holds back and the receiver
  // refuses a transfer; each phase sets its own pair.
  int in_idle_pct   = 0;
  int out_stall_pct = 0;

  // Level of the walk that the bench is driving, in the package's codes.
  logic [LEVEL_W-1:0] plan_lvl;

  ptw_in_if  walk_in_ch ();
  ptw_out_if walk_out_ch ();

  four_level_page_table_walker_top uut (
    .clk      (clk),
    .rst      (rst),
    .walk_in  (walk_in_ch),
    .walk_out (walk_out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  ptw_walk_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .walk_in    (walk_in_ch),
    .walk_out   (walk_out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The receiver decides anew at every edge whether it takes a transfer.
  initial begin
    walk_out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      walk_out_ch.ready <= !rst && ($urandom_range(99) >= out_stall_pct);
    end
  end

  // A hung handshake ends the run here. The slowest correct run needs well
  // under a tenth of this time.
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Drives one item and returns at the edge where it is transferred. Valid
  // stays high into the next call, which either lowers it for a gap or
  // puts the next item on the channel, so only one assignment is made per
  // step.
  task automatic send(input logic act, input logic [VA_W-1:0] va,
                      input logic [ENTRY_W-1:0] data);
    while ($urandom_range(99) < in_idle_pct) begin
      walk_in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    walk_in_ch.valid <= 1'b1;
    walk_in_ch.action <= act;
    walk_in_ch.virtual_address <= va;
    walk_in_ch.read_data <= data;
    @(posedge clk);
    while (!walk_in_ch.ready) @(posedge clk);
  endtask

  // The unused field of each item carries random bits, so every input bit
  // toggles in both kinds of item.
  task automatic translate(input logic [VA_W-1:0] va);
    send(ACT_TRANSLATE, va, rand64());
  endtask

  task automatic respond(input logic [ENTRY_W-1:0] entry);
    send(ACT_RESPONSE, VA_W'(rand64()), entry);
  endtask

  // Register write: a setup phase, then an access phase that completes at
  // the first edge with pready high.
  task automatic write_root(input logic [FRAME_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_ROOT_FRAME;
    pwdata <= {{(APB_DATA_W-FRAME_W){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Stops sending and waits until the checker has seen every expected
  // result. The first edge lets the count of the last transfer settle; the
  // extra cycles cover the output stage after a dropped item.
  task automatic drain();
    walk_in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Mostly complete walks with random addresses and entries. A few items
  // are sent in the wrong state (a response with no walk, a translate in
  // the middle of one); those are dropped by the block and not counted.
  // The phase always ends with the walk finished.
  task automatic random_walks(input int count);
    int               done;
    int               pick;
    logic [ENTRY_W-1:0] entry;
    done = 0;
    while (done < count || plan_lvl != LVL_IDLE) begin
      pick = $urandom_range(99);
      if (plan_lvl == LVL_IDLE) begin
        if (pick < 8) begin
          respond(rand64());
        end else begin
          translate(VA_W'(rand64()));
          plan_lvl = LVL_PML4;
          done++;
        end
      end else if (pick < 6) begin
        translate(VA_W'(rand64()));
      end else begin
        entry = rand64();
        entry[ENTRY_PRESENT_BIT] = 1'b1;
        pick = $urandom_range(99);
        if (pick < 12) begin
          // The entry is not present, whatever the rest of it holds.
          entry[ENTRY_PRESENT_BIT] = 1'b0;
          plan_lvl = LVL_IDLE;
        end else begin
          case (plan_lvl)
            LVL_PML4: begin
              // The page-size bit stays random here; it is ignored.
              plan_lvl = LVL_PDP;
            end
            LVL_PDP, LVL_PD: begin
              entry[ENTRY_HUGE_BIT] = (pick < 30);
              plan_lvl = entry[ENTRY_HUGE_BIT] ? LVL_IDLE : plan_lvl + 3'd1;
            end
            default: begin
              plan_lvl = LVL_IDLE;
            end
          endcase
        end
        respond(entry);
        done++;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    walk_in_ch.valid = 1'b0;
    walk_in_ch.action = ACT_TRANSLATE;
    walk_in_ch.virtual_address = '0;
    walk_in_ch.read_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    plan_lvl = LVL_IDLE;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with the largest root frame so that the first read
    // address uses every bit of the frame field.
    write_root({FRAME_W{1'b1}});

    // A response with no walk in progress is dropped.
    respond('1);

    // Full 4 KB walk from the lowest address. The PML4 entry has only the
    // present bit; a translate sent in the middle of the walk is dropped.
    // The PT entry has the page-size bit set, which does not matter there,
    // and bit 63 set, which must not reach the frame number.
    translate('0);
    respond(64'h1);
    translate('1);
    respond(64'hffff_ffff_ffff_ff7f);
    respond(64'hffff_ffff_ffff_ff7f);
    respond('1);

    // The page-size bit at the PML4 level is ignored, at the PDP level it
    // marks a 1 GB page, which the walker does not support.
    translate('1);
    respond('1);
    respond('1);

    // A 2 MB page below a PML4 entry whose only other bit is bit 63.
    translate(48'h8000_4020_1000);
    respond(64'h8000_0000_0000_0001);
    respond(64'h1);
    respond('1);

    // A missing entry at each of the four levels.
    translate(48'h7fff_ffff_ffff);
    respond(64'hffff_ffff_ffff_fffe);
    translate(48'h0000_0000_0fff);
    respond(64'h1);
    respond('0);
    translate(48'h0080_4020_1000);
    respond(64'h1);
    respond(64'h1);
    respond(64'hffff_ffff_ffff_fffe);
    translate(48'hffff_ffff_f000);
    respond(64'h1);
    respond(64'h1);
    respond(64'h1);
    respond('0);
    drain();

    // Random phases: no idling, sender idle, receiver stalling, both. The
    // root frame is zero, then random, then all ones, then random again.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          in_idle_pct = 0;
          out_stall_pct = 0;
          write_root('0);
        end
        1: begin
          in_idle_pct = 79;
          out_stall_pct = 0;
          write_root(FRAME_W'(rand64()));
        end
        2: begin
          in_idle_pct = 0;
          out_stall_pct = 79;
          write_root({FRAME_W{1'b1}});
        end
        default: begin
          in_idle_pct = 28;
          out_stall_pct = 28;
          write_root(FRAME_W'(rand64()));
        end
      endcase
      random_walks(ITEMS_PER_PHASE);
      drain();
    end

    // A result still expected at this point means one went missing.
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
